// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit: opcodes, status
// codes, sequencer states and the divider status group.
// ----------------------------------------------------------------------------
package rau_pkg;

    // port width of every operand and result field
    localparam int DATA_W = 32;

    // default operand width handed to the core
    localparam int OPERAND_WIDTH_DFLT = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_ZCHK,
        S_TWO,
        S_STRU,
        S_STRV,
        S_SUB,
        S_DN0,
        S_DN1,
        S_DD0,
        S_DD1,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// Shared unsigned magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
    parameter int W = rau_pkg::OPERAND_WIDTH_DFLT
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    import rau_pkg::*;

    logic [2*W-1:0] r_p;

    // register the product
    always_ff @(posedge i_clk) begin
        r_p <= (2*W)'(i_a) * (2*W)'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module rau_div #(
    parameter int DW = 2 * rau_pkg::OPERAND_WIDTH_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_numer,
    input  logic [DW-1:0]       i_denom,
    output logic [DW-1:0]       o_quo,
    output rau_pkg::t_div_stat  o_stat
);
    import rau_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // one restoring step
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_numer;
            n_den  = i_denom;
            n_cnt  = CW'(DW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // hold control under reset, advance the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ===== hdl/rational_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Add, subtract, multiply or divide two signed fractions and reduce the
// result by the gcd of numerator and denominator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry an opcode and two fractions. A word
//   is taken when i_valid is high and o_stall is low; o_stall is high from
//   acceptance until the result has been written to the output register.
//   Output channel: o_valid / i_stall carry the reduced fraction and a status.
//   The output register frees the input side: a new word may be taken while
//   the previous result still waits.
//   Sequence: the cross products go through one shared multiplier, then add
//   and subtract form the sum and the numerator is tested for zero. The gcd
//   runs a binary shift-and-subtract loop, one step per cycle, for a data
//   dependent number of steps. The two quotients share one divider, and a
//   final state writes the result. A zero numerator skips the gcd and the
//   division; an error goes straight to the final state. One word is in
//   flight at a time, so the next word can be taken in the cycle after the
//   result is written.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending result. If the receiver stalls, the finished result is held
//   and the sequencer waits in its final state until the register frees.
// ----------------------------------------------------------------------------
module rational_arith_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DFLT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_opcode,
    input  logic signed [rau_pkg::DATA_W-1:0] i_a_num,
    input  logic signed [rau_pkg::DATA_W-1:0] i_a_den,
    input  logic signed [rau_pkg::DATA_W-1:0] i_b_num,
    input  logic signed [rau_pkg::DATA_W-1:0] i_b_den,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [rau_pkg::DATA_W-1:0] o_result_num,
    output logic signed [rau_pkg::DATA_W-1:0] o_result_den,
    output logic [1:0]                       o_status
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = 2 * W;
    localparam logic [DW-1:0] LIM = DW'(1) << (W - 1);

    t_state         r_state, n_state;
    t_op            r_op, n_op;
    t_status        r_status, n_status;
    logic [W-1:0]   r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic           r_an_neg, n_an_neg, r_ad_neg, n_ad_neg;
    logic           r_bn_neg, n_bn_neg, r_bd_neg, n_bd_neg;
    logic           r_psign, n_psign;
    logic [DW-1:0]  r_num, n_num, r_den, n_den, r_t, n_t;
    logic           r_num_neg, n_num_neg, r_den_neg, n_den_neg, r_t_neg, n_t_neg;
    logic [DW-1:0]  r_u, n_u, r_v, n_v, r_nsh, n_nsh, r_dsh, n_dsh;
    logic           r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_res_num, n_res_num, r_res_den, n_res_den;
    t_status        r_res_st, n_res_st;

    logic [W-1:0]   w_an_raw, w_ad_raw, w_bn_raw, w_bd_raw;
    logic [W-1:0]   w_mx, w_my;
    logic [DW-1:0]  w_prod;
    logic           w_pneg;
    logic           w_div_start;
    logic [DW-1:0]  w_div_numer, w_div_quo;
    t_div_stat      w_div_stat;
    logic           w_tneg;
    logic           w_accept;
    logic           w_fit_n, w_fit_d;
    logic signed [W-1:0] w_emit_n, w_emit_d;

    // operand fields at operand width
    assign w_an_raw = i_a_num[W-1:0];
    assign w_ad_raw = i_a_den[W-1:0];
    assign w_bn_raw = i_b_num[W-1:0];
    assign w_bd_raw = i_b_den[W-1:0];

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);

    // shared multiplier and divider
    rau_mul #(.W(W)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mx),
        .i_b   (w_my),
        .o_p   (w_prod)
    );

    rau_div #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (w_div_numer),
        .i_denom (r_u),
        .o_quo   (w_div_quo),
        .o_stat  (w_div_stat)
    );

    assign w_pneg      = r_psign && (w_prod != '0);
    assign w_div_start = (r_state == S_DN0) || (r_state == S_DD0);
    assign w_div_numer = (r_state == S_DD0) ? r_dsh : r_nsh;
    assign w_tneg      = (r_op == OP_SUB) ? ~r_t_neg : r_t_neg;

    // range check and two's complement form of the reduced fraction
    assign w_fit_n  = r_num_neg ? (r_num <= LIM) : (r_num < LIM);
    assign w_fit_d  = r_den_neg ? (r_den <= LIM) : (r_den < LIM);
    assign w_emit_n = r_num_neg ? W'(-r_num[W-1:0]) : r_num[W-1:0];
    assign w_emit_d = r_den_neg ? W'(-r_den[W-1:0]) : r_den[W-1:0];

    // sequencer: next state and datapath updates
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_status  = r_status;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_an_neg  = r_an_neg;
        n_ad_neg  = r_ad_neg;
        n_bn_neg  = r_bn_neg;
        n_bd_neg  = r_bd_neg;
        n_psign   = r_psign;
        n_num     = r_num;
        n_den     = r_den;
        n_t       = r_t;
        n_num_neg = r_num_neg;
        n_den_neg = r_den_neg;
        n_t_neg   = r_t_neg;
        n_u       = r_u;
        n_v       = r_v;
        n_nsh     = r_nsh;
        n_dsh     = r_dsh;
        n_o_valid = r_o_valid;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_res_st  = r_res_st;
        w_mx      = r_ad;
        w_my      = r_bn;

        // drop the result once taken
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = t_op'(i_opcode);
                    n_an_neg = w_an_raw[W-1];
                    n_ad_neg = w_ad_raw[W-1];
                    n_bn_neg = w_bn_raw[W-1];
                    n_bd_neg = w_bd_raw[W-1];
                    n_an     = w_an_raw[W-1] ? W'(-w_an_raw) : w_an_raw;
                    n_ad     = w_ad_raw[W-1] ? W'(-w_ad_raw) : w_ad_raw;
                    n_bn     = w_bn_raw[W-1] ? W'(-w_bn_raw) : w_bn_raw;
                    n_bd     = w_bd_raw[W-1] ? W'(-w_bd_raw) : w_bd_raw;
                    if (w_ad_raw == '0 || w_bd_raw == '0 ||
                        (t_op'(i_opcode) == OP_DIV && w_bn_raw == '0)) begin
                        n_status = ST_ZERO;
                        n_state  = S_FIN;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                w_mx    = r_an;
                w_my    = (r_op == OP_MUL) ? r_bn : r_bd;
                n_psign = r_an_neg ^ ((r_op == OP_MUL) ? r_bn_neg : r_bd_neg);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                w_mx      = r_ad;
                w_my      = (r_op == OP_DIV) ? r_bn : r_bd;
                n_psign   = r_ad_neg ^ ((r_op == OP_DIV) ? r_bn_neg : r_bd_neg);
                n_num     = w_prod;
                n_num_neg = w_pneg;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                w_mx      = r_ad;
                w_my      = r_bn;
                n_psign   = r_ad_neg ^ r_bn_neg;
                n_den     = w_prod;
                n_den_neg = w_pneg;
                n_state   = S_MUL3;
            end
            S_MUL3: begin
                n_t     = w_prod;
                n_t_neg = w_pneg;
                n_state = S_SUM;
            end
            S_SUM: begin
                // signed-magnitude sum for add and subtract
                if (r_op == OP_ADD || r_op == OP_SUB) begin
                    if (r_num_neg == w_tneg) begin
                        n_num = r_num + r_t;
                    end else if (r_num >= r_t) begin
                        n_num = r_num - r_t;
                    end else begin
                        n_num     = r_t - r_num;
                        n_num_neg = w_tneg;
                    end
                end
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                if (r_num == '0) begin
                    n_num_neg = 1'b0;
                    n_den     = DW'(1);
                    n_state   = S_FIN;
                end else begin
                    n_u     = r_num;
                    n_v     = r_den;
                    n_nsh   = r_num;
                    n_dsh   = r_den;
                    n_state = S_TWO;
                end
            end
            S_TWO: begin
                // strip common factors of two from all four values
                if (!r_u[0] && !r_v[0]) begin
                    n_u   = r_u >> 1;
                    n_v   = r_v >> 1;
                    n_nsh = r_nsh >> 1;
                    n_dsh = r_dsh >> 1;
                end else begin
                    n_state = S_STRU;
                end
            end
            S_STRU: begin
                if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else begin
                    n_state = S_STRV;
                end
            end
            S_STRV: begin
                if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (r_u == r_v) begin
                    n_state = S_DN0;
                end else if (r_u > r_v) begin
                    n_u     = r_u - r_v;
                    n_state = S_STRU;
                end else begin
                    n_v     = r_v - r_u;
                    n_state = S_STRV;
                end
            end
            S_DN0: begin
                n_state = S_DN1;
            end
            S_DN1: begin
                if (w_div_stat.done) begin
                    n_num   = w_div_quo;
                    n_state = S_DD0;
                end
            end
            S_DD0: begin
                n_state = S_DD1;
            end
            S_DD1: begin
                if (w_div_stat.done) begin
                    n_den   = w_div_quo;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // write the result once the output register is free
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    if (r_status != ST_OK) begin
                        n_res_st  = r_status;
                        n_res_num = '0;
                        n_res_den = '0;
                    end else if (!w_fit_n || !w_fit_d) begin
                        n_res_st  = ST_OVF;
                        n_res_num = '0;
                        n_res_den = '0;
                    end else begin
                        n_res_st  = ST_OK;
                        n_res_num = DATA_W'(w_emit_n);
                        n_res_den = DATA_W'(w_emit_d);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and valid under reset, datapath free running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_op      <= n_op;
        r_status  <= n_status;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_an_neg  <= n_an_neg;
        r_ad_neg  <= n_ad_neg;
        r_bn_neg  <= n_bn_neg;
        r_bd_neg  <= n_bd_neg;
        r_psign   <= n_psign;
        r_num     <= n_num;
        r_den     <= n_den;
        r_t       <= n_t;
        r_num_neg <= n_num_neg;
        r_den_neg <= n_den_neg;
        r_t_neg   <= n_t_neg;
        r_u       <= n_u;
        r_v       <= n_v;
        r_nsh     <= n_nsh;
        r_dsh     <= n_dsh;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_st  <= n_res_st;
    end

    assign o_valid      = r_o_valid;
    assign o_result_num = r_res_num;
    assign o_result_den = r_res_den;
    assign o_status     = r_res_st;

    // a failed result carries a zero fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res_st != ST_OK) |-> (r_res_num == '0 && r_res_den == '0))
        else $error("error result with nonzero fraction");

    // a good result never has a zero denominator
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res_st == ST_OK) |-> (r_res_den != '0))
        else $error("ok result with zero denominator");

    // divider is only started when idle
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    // divider completion only seen while waiting for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DN1 || r_state == S_DD1))
        else $error("divider done outside wait state");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rational_arith_unit_core. A directed set of words
// covers the operand extremes, every opcode, zero denominators, division by a
// zero fraction, overflow and zero numerators. About 1800 random words follow.
// Both channels idle at random. Every result is checked field by field
// against an expectation that the bench works out when the word is accepted.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    // signed magnitude at double width
    typedef struct {
        bit              neg;
        longint unsigned mag;
    } t_smag;

    typedef struct {
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
        t_status           status;
    } t_fraction_res;

    // ------------------------------------------------------------------------
    // Predicted fractions in order of acceptance
    // ------------------------------------------------------------------------
    class fraction_board;
        t_fraction_res pending[$];
        int            mismatches;
        int            n_ok, n_zero, n_ovf;

        function t_smag split(logic [DATA_W-1:0] v);
            t_smag s;
            s.neg = v[DATA_W-1];
            s.mag = s.neg ? {32'b0, DATA_W'(-v)} : {32'b0, v};
            return s;
        endfunction

        function t_smag times(t_smag x, t_smag y);
            t_smag r;
            r.mag = x.mag * y.mag;
            r.neg = (r.mag != 0) && (x.neg != y.neg);
            return r;
        endfunction

        function t_smag plus(t_smag x, t_smag y);
            t_smag r;
            if (x.neg == y.neg) begin
                r.mag = x.mag + y.mag;
                r.neg = x.neg;
            end else if (x.mag >= y.mag) begin
                r.mag = x.mag - y.mag;
                r.neg = x.neg;
            end else begin
                r.mag = y.mag - x.mag;
                r.neg = y.neg;
            end
            if (r.mag == 0) r.neg = 0;
            return r;
        endfunction

        function bit fits32(t_smag s);
            longint unsigned lim;
            lim = 64'd1 << (DATA_W - 1);
            return s.neg ? (s.mag <= lim) : (s.mag < lim);
        endfunction

        // note an accepted word: work out its reduced fraction
        function void note_word(t_op op, logic [DATA_W-1:0] an, logic [DATA_W-1:0] ad,
                                logic [DATA_W-1:0] bn, logic [DATA_W-1:0] bd);
            t_smag           xn, xd, yn, yd, rn, rd, t;
            longint unsigned p, q, r;
            t_fraction_res   e;
            xn = split(an);
            xd = split(ad);
            yn = split(bn);
            yd = split(bd);
            e.num = '0;
            e.den = '0;
            if (xd.mag == 0 || yd.mag == 0 || (op == OP_DIV && yn.mag == 0)) begin
                e.status = ST_ZERO;
            end else begin
                case (op)
                    OP_ADD: begin
                        rn = plus(times(xn, yd), times(xd, yn));
                        rd = times(xd, yd);
                    end
                    OP_SUB: begin
                        t = times(xd, yn);
                        if (t.mag != 0) t.neg = !t.neg;
                        rn = plus(times(xn, yd), t);
                        rd = times(xd, yd);
                    end
                    OP_MUL: begin
                        rn = times(xn, yn);
                        rd = times(xd, yd);
                    end
                    default: begin
                        rn = times(xn, yd);
                        rd = times(xd, yn);
                    end
                endcase
                // Euclid on the magnitudes
                p = rn.mag;
                q = rd.mag;
                r = p % q;
                while (r != 0) begin
                    p = q;
                    q = r;
                    r = p % q;
                end
                rn.mag = rn.mag / q;
                rd.mag = rd.mag / q;
                if (!fits32(rn) || !fits32(rd)) begin
                    e.status = ST_OVF;
                end else begin
                    e.status = ST_OK;
                    e.num = rn.neg ? DATA_W'(-rn.mag) : DATA_W'(rn.mag);
                    e.den = rd.neg ? DATA_W'(-rd.mag) : DATA_W'(rd.mag);
                end
            end
            pending.push_back(e);
        endfunction

        // check one accepted result against the oldest prediction
        function void check_word(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den,
                                 logic [1:0] st);
            t_fraction_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result num=%h den=%h status=%0d",
                         $time, num, den, st);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            case (e.status)
                ST_OK:   n_ok++;
                ST_ZERO: n_zero++;
                default: n_ovf++;
            endcase
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                mismatches++;
            end
            if (num !== e.num) begin
                $display("%0t: result_num expected %h actual %h", $time, e.num, num);
                mismatches++;
            end
            if (den !== e.den) begin
                $display("%0t: result_den expected %h actual %h", $time, e.den, den);
                mismatches++;
            end
        endfunction
    endclass

    localparam int N_RANDOM   = 1800;
    localparam int HOLD_LONG  = 700;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN      = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_stall = 1'b0;
    logic [1:0]        i_opcode = '0;
    logic [DATA_W-1:0] i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic              o_stall, o_valid;
    logic [DATA_W-1:0] o_result_num, o_result_den;
    logic [1:0]        o_status;

    fraction_board board = new();
    bit                hold_request = 0;
    int                idle_cycles = 0;
    int                words_sent = 0;

    rational_arith_unit_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result_num (o_result_num),
        .o_result_den (o_result_den),
        .o_status     (o_status)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d words outstanding", $time, board.pending.size());
            $display("FAIL rational_arith_unit_core");
            $finish;
        end
    end

    // check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_result_num, o_result_den, o_status);
    end

    // receiver: random stall, mostly short, sometimes long, plus one long hold
    initial begin : receiver
        int left;
        int k;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall = 1'b1;
                for (k = 0; k < HOLD_LONG; k++) @(negedge i_clk);
                hold_request = 0;
                i_stall = 1'b0;
            end else if (left > 0) begin
                left--;
                i_stall = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2: left = $urandom_range(0, 3);
                    3:       left = $urandom_range(20, 120);
                    default: left = 0;
                endcase
                i_stall = (left > 0);
            end
        end
    end

    // offer one word and hold it until taken; returns at a falling edge
    task automatic send_word(t_op op, logic [DATA_W-1:0] an, logic [DATA_W-1:0] ad,
                             logic [DATA_W-1:0] bn, logic [DATA_W-1:0] bd);
        i_valid  = 1'b1;
        i_opcode = op;
        i_a_num  = an;
        i_a_den  = ad;
        i_b_num  = bn;
        i_b_den  = bd;
        do @(posedge i_clk); while (o_stall);
        board.note_word(op, an, ad, bn, bd);
        words_sent++;
        @(negedge i_clk);
    endtask

    // drop valid for a random gap, mostly none or short
    task automatic sender_gap();
        int n;
        case ($urandom_range(0, 15))
            0, 1, 2: n = $urandom_range(1, 4);
            3:       n = $urandom_range(30, 200);
            default: n = 0;
        endcase
        if (n > 0) begin
            i_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // random operand: mostly small so reductions land in range
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] specials[5];
        specials = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 60)) - 30);
            4:          return DATA_W'(int'($urandom_range(0, 2000)) - 1000) * 12;
            5:          return DATA_W'(int'($urandom_range(0, 131072)) - 65536);
            6, 7:       return $urandom();
            default:    return specials[$urandom_range(0, 4)];
        endcase
    endfunction

    initial begin : stimulus
        logic [DATA_W-1:0] mx, mn, m1;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        m1 = 32'hFFFF_FFFF;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words
        send_word(OP_ADD, 1, 2, 1, 3);
        send_word(OP_SUB, 1, 2, 1, 2);          // zero numerator
        send_word(OP_SUB, 1, m1, 1, 2);         // negative result denominator
        send_word(OP_MUL, -3, 4, 2, -9);
        send_word(OP_DIV, 3, 4, -6, 8);
        send_word(OP_ADD, 5, 0, 1, 1);          // zero left denominator
        send_word(OP_MUL, 5, 7, 1, 0);          // zero right denominator
        send_word(OP_DIV, 5, 7, 0, 3);          // divide by zero fraction
        send_word(OP_DIV, 0, 7, 0, 0);
        send_word(OP_MUL, mx, 1, mx, 1);        // overflow
        send_word(OP_MUL, mn, 1, m1, 1);        // min times -1 overflows
        send_word(OP_MUL, mn, 1, 1, 1);         // min fits
        send_word(OP_DIV, mn, mn, mn, mn);
        send_word(OP_ADD, mx, mn, mx, mn);
        send_word(OP_SUB, mn, mx, mx, mn);
        send_word(OP_ADD, mn, 1, mn, 1);        // sum needs 33 bits
        send_word(OP_DIV, mx, m1, mn, m1);
        send_word(OP_MUL, 0, mn, 0, mx);
        send_word(OP_SUB, m1, m1, m1, m1);
        send_word(OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);

        // receiver holds off while words keep coming, so the input stalls
        hold_request = 1;
        for (int k = 0; k < N_RANDOM; k++) begin
            send_word(t_op'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
            if (k == N_RANDOM / 2) begin
                // pause until every outstanding result has come back
                i_valid = 1'b0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
            sender_gap();
        end
        i_valid = 1'b0;

        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("Covered %0d words: %0d reduced, %0d zero-divisor errors, %0d overflows.",
                 words_sent, board.n_ok, board.n_zero, board.n_ovf);
        $display("Mismatches: %0d, words still outstanding: %0d.",
                 board.mismatches, board.pending.size());
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("PASS rational_arith_unit_core");
        else
            $display("FAIL rational_arith_unit_core");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_div.sv
hdl/rational_arith_unit_core.sv
test/tb_top.sv
